@@ hw/rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the block.
// No dependencies; included by bare file name where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every rising edge, disabled while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed on clocked property");

// Next-cycle implication, disabled while reset is active.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed on next-cycle property");

`endif

@@ hw/rtl/bnrc_pkg.sv @@
// Package of the button navigation and refresh controller.
// Holds payload structs, register widths, button numbering and defaults; no dependencies.
package bnrc_pkg;

    // Register widths and reset values.
    localparam int DB_W      = 8;
    localparam int PERIOD_W  = 24;
    localparam int FULL_W    = 5;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = PERIOD_W;

    localparam logic [DB_W-1:0]     DEBOUNCE_RESET = 8'd25;
    localparam logic [PERIOD_W-1:0] PERIOD_RESET   = 24'd900000;
    localparam logic [FULL_W-1:0]   FULL_RESET     = 5'd12;
    localparam logic [PERIOD_W-1:0] TICK_MAX       = {PERIOD_W{1'b1}};
    localparam logic [DB_W-1:0]     COUNT_MAX      = {DB_W{1'b1}};
    localparam logic [FULL_W-1:0]   PARTIAL_MAX    = {FULL_W{1'b1}};

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_MS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REFRESH_MS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SCRUB_GAP    = 2'd2;

    // Page and row defaults.
    localparam int PAGES_DEFAULT = 3;
    localparam int ROWS_DEFAULT  = 4;
    localparam logic [1:0] ACT_PAGE = 2'd2;

    // Button numbering.
    localparam int NBTN     = 5;
    localparam int BTN_MENU = 0;
    localparam int BTN_EXIT = 1;
    localparam int BTN_UP   = 2;
    localparam int BTN_DOWN = 3;
    localparam int BTN_CONF = 4;

    typedef logic [DB_W-1:0] db_ms_t;

    typedef struct packed {
        logic menu_level;
        logic exit_level;
        logic up_level;
        logic down_level;
        logic confirm_level;
    } bnrc_in_t;

    typedef struct packed {
        logic [1:0] page_shown;
        logic [1:0] focus_row;
        logic       full_redraw;
        logic       data_refresh;
        logic       toggle_request;
    } bnrc_out_t;

endpackage

@@ hw/rtl/bnrc_debounce.sv @@
// Debouncer for one active-low button: reports one press per settled transition to pressed.
// Depends on bnrc_pkg for the count width.
module bnrc_debounce
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            enable,
    input  logic            level,
    input  bnrc_pkg::db_ms_t debounce_ms,
    output logic            press
);
    import bnrc_pkg::*;

    logic   last_reg, last_next;
    logic   settled_reg, settled_next;
    db_ms_t count_reg, count_next;
    logic   raw;
    logic   accept;

    // A change of level restarts the count; a steady level counts up and saturates.
    always_comb
    begin
        raw = ~level;
        last_next = raw;
        if (raw != last_reg)
        begin
            count_next = '0;
        end
        else if (count_reg != COUNT_MAX)
        begin
            count_next = count_reg + 1'b1;
        end
        else
        begin
            count_next = count_reg;
        end
        accept = (count_next >= debounce_ms) && (raw != settled_reg);
        settled_next = accept ? raw : settled_reg;
        press = accept & raw;
    end

    // State advances once per processed millisecond.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg    <= 1'b0;
            settled_reg <= 1'b0;
            count_reg   <= '0;
        end
        else if (enable)
        begin
            last_reg    <= last_next;
            settled_reg <= settled_next;
            count_reg   <= count_next;
        end
    end

endmodule

@@ hw/rtl/button_nav_refresh_controller_unit.sv @@
// Top level of the button navigation and refresh controller.
// Depends on bnrc_pkg and bnrc_debounce.
//
// Usage: each request on the input channel is one elapsed millisecond and carries
// the raw active-low levels of the menu, exit, up, down and confirm buttons.
// A request is taken at a rising edge with in_valid high and in_stall low.
// A millisecond that changes the page, fires the data tick or acts on the
// actuator page yields one result request; other milliseconds yield none.
// Results are taken at a rising edge with out_valid high and out_stall low.
// A result passes through the input register, loaded at the accepting edge, and
// the result register, loaded when the input stage advances. Throughput: one
// input per cycle while the receiver does not stall, set by the single pass of
// debounce, page and redraw logic between them. When the receiver stalls the
// result register holds and the input register fills; in_stall then rises until
// the result is taken. Configuration: cfg_we writes cfg_data to the register
// chosen by cfg_index (0 debounce, 1 refresh period, 2 full-redraw spacing); the
// user must write only while the block is idle, which the block does not enforce.
// Reset clears the valid flags and controller state and loads the default values.
module button_nav_refresh_controller_unit
#(
    parameter int PAGES = bnrc_pkg::PAGES_DEFAULT,
    parameter int ROWS  = bnrc_pkg::ROWS_DEFAULT
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  bnrc_pkg::bnrc_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bnrc_pkg::bnrc_out_t                 out_data,
    input  logic                                cfg_we,
    input  logic [bnrc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bnrc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import bnrc_pkg::*;

    localparam logic [1:0] LAST_PAGE = 2'(PAGES - 1);
    localparam logic [1:0] LAST_ROW  = 2'(ROWS - 1);

    // Configuration registers.
    db_ms_t              debounce_ms_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [FULL_W-1:0]   scrub_gap_reg;

    // Input stage.
    logic     in_valid_reg;
    bnrc_in_t in_data_reg;

    // Controller state.
    logic [PERIOD_W-1:0] tick_reg, tick_next;
    logic [1:0]          page_reg, page_next;
    logic [1:0]          focus_reg, focus_next;
    logic [FULL_W-1:0]   partials_reg, partials_next;

    // Result stage.
    logic      out_valid_reg;
    bnrc_out_t out_data_reg;
    logic      emit;
    bnrc_out_t result;

    logic             advance;
    logic [NBTN-1:0]  levels;
    logic [NBTN-1:0]  press;
    logic [PERIOD_W-1:0] tick_inc;
    logic             tick;
    logic             page_changed;
    logic             in_page;
    logic             full;

    // The input stage moves on when the result register is free or being emptied.
    assign advance  = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_ms_reg <= DEBOUNCE_RESET;
            period_reg      <= PERIOD_RESET;
            scrub_gap_reg   <= FULL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_MS: debounce_ms_reg <= cfg_data[DB_W-1:0];
                CFG_REFRESH_MS:  period_reg      <= cfg_data[PERIOD_W-1:0];
                CFG_SCRUB_GAP:   scrub_gap_reg   <= cfg_data[FULL_W-1:0];
                default:         ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_valid && !in_stall)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // One debouncer per button.
    always_comb
    begin
        levels           = '0;
        levels[BTN_MENU] = in_data_reg.menu_level;
        levels[BTN_EXIT] = in_data_reg.exit_level;
        levels[BTN_UP]   = in_data_reg.up_level;
        levels[BTN_DOWN] = in_data_reg.down_level;
        levels[BTN_CONF] = in_data_reg.confirm_level;
    end

    for (genvar b = 0; b < NBTN; b++)
    begin : g_btn
        bnrc_debounce u_debounce
        (
            .clk         (clk),
            .rst_n       (rst_n),
            .enable      (advance),
            .level       (levels[b]),
            .debounce_ms (debounce_ms_reg),
            .press       (press[b])
        );
    end

    // Data tick, page stepping, focus and redraw scheduling for one millisecond.
    always_comb
    begin
        tick_inc = (tick_reg != TICK_MAX) ? tick_reg + 1'b1 : tick_reg;
        tick = (tick_inc >= period_reg);
        tick_next = tick ? '0 : tick_inc;
        page_changed = tick;

        page_next = page_reg;
        if (press[BTN_MENU])
        begin
            page_next = (page_next == 2'd0) ? LAST_PAGE : page_next - 1'b1;
            page_changed = 1'b1;
        end
        if (press[BTN_EXIT])
        begin
            page_next = (page_next == LAST_PAGE) ? 2'd0 : page_next + 1'b1;
            page_changed = 1'b1;
        end

        focus_next = focus_reg;
        in_page = 1'b0;
        if ((page_next == ACT_PAGE) && !page_changed)
        begin
            if (press[BTN_UP])
            begin
                focus_next = (focus_next == 2'd0) ? LAST_ROW : focus_next - 1'b1;
                in_page = 1'b1;
            end
            if (press[BTN_DOWN])
            begin
                focus_next = (focus_next == LAST_ROW) ? 2'd0 : focus_next + 1'b1;
                in_page = 1'b1;
            end
            if (press[BTN_CONF])
            begin
                in_page = 1'b1;
            end
        end

        // A page change is always full; once the allowed partials are used up,
        // the next partial becomes a full scrub.
        partials_next = partials_reg;
        full = 1'b0;
        if (page_changed)
        begin
            full = 1'b1;
            partials_next = '0;
        end
        else if (in_page)
        begin
            if (partials_reg >= scrub_gap_reg)
            begin
                full = 1'b1;
                partials_next = '0;
            end
            else if (partials_reg != PARTIAL_MAX)
            begin
                partials_next = partials_reg + 1'b1;
            end
        end

        emit = page_changed || in_page;
        result.page_shown     = page_next;
        result.focus_row      = focus_next;
        result.full_redraw    = full;
        result.data_refresh   = tick;
        result.toggle_request = in_page && press[BTN_CONF];
    end

    // Controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_reg     <= '0;
            page_reg     <= '0;
            focus_reg    <= '0;
            partials_reg <= '0;
        end
        else if (advance)
        begin
            tick_reg     <= tick_next;
            page_reg     <= page_next;
            focus_reg    <= focus_next;
            partials_reg <= partials_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

endmodule

@@ hw/rtl/bnrc_checker.sv @@
// Port-level checker of the button navigation and refresh controller, with its bind.
// Depends on bnrc_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bnrc_checker
#(
    parameter int PAGES = bnrc_pkg::PAGES_DEFAULT
)
(
    input logic                clk,
    input logic                rst_n,
    input logic                out_valid,
    input logic                out_stall,
    input bnrc_pkg::bnrc_out_t out_data
);
    import bnrc_pkg::*;

    // A stalled result stays offered and unchanged.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))

    // The page shown is always one of the configured pages.
    `ASSERT_CLK(a_page_range, clk, rst_n, out_valid |-> (32'(out_data.page_shown) < PAGES))

    // A data tick always brings a full redraw.
    `ASSERT_CLK(a_tick_full, clk, rst_n,
        (out_valid && out_data.data_refresh) |-> out_data.full_redraw)

    // A toggle request only comes from the actuator page, never with a data tick.
    `ASSERT_CLK(a_toggle_page, clk, rst_n,
        (out_valid && out_data.toggle_request) |->
            (out_data.page_shown == ACT_PAGE && !out_data.data_refresh))

endmodule

bind button_nav_refresh_controller_unit bnrc_checker #(.PAGES(PAGES)) u_bnrc_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
);

@@ tb/sv/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for button_nav_refresh_controller_unit.
// Depends on bnrc_pkg; predicts each redraw request from the button levels and compares it.
module tb_top;
    import bnrc_pkg::*;

    localparam int N_PAGES      = PAGES_DEFAULT;
    localparam int N_ROWS       = ROWS_DEFAULT;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_MS    = 300;

    // Index beyond the last register; a write to it must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;

    // One-hot masks of held buttons, indexed by the package numbering.
    localparam logic [NBTN-1:0] HOLD_NONE = '0;
    localparam logic [NBTN-1:0] HOLD_MENU = NBTN'(1 << BTN_MENU);
    localparam logic [NBTN-1:0] HOLD_EXIT = NBTN'(1 << BTN_EXIT);
    localparam logic [NBTN-1:0] HOLD_UP   = NBTN'(1 << BTN_UP);
    localparam logic [NBTN-1:0] HOLD_DOWN = NBTN'(1 << BTN_DOWN);
    localparam logic [NBTN-1:0] HOLD_CONF = NBTN'(1 << BTN_CONF);

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    bnrc_in_t              in_data;
    logic                  out_valid;
    logic                  out_stall;
    bnrc_out_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predictor state and its copy of the registers.
    logic                  raw_prev [NBTN];
    logic                  settled  [NBTN];
    logic [DB_W-1:0]       hold_ms  [NBTN];
    logic [PERIOD_W-1:0]   since_tick;
    int                    page_now;
    int                    focus_now;
    logic [FULL_W-1:0]     partial_run;
    logic [DB_W-1:0]       cur_debounce;
    logic [PERIOD_W-1:0]   cur_period;
    logic [FULL_W-1:0]     cur_scrub_gap;

    bnrc_out_t             redraw_q [$];
    int                    mismatches = 0;
    int                    ms_sent = 0;
    bit                    calm = 1'b0;

    button_nav_refresh_controller_unit #(
        .PAGES (N_PAGES),
        .ROWS  (N_ROWS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock with a 4 ns period.
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // The receiver stalls now and then, except during the calm stretch.
    always @(negedge clk)
    begin
        out_stall <= !calm && ($urandom_range(99) < 6);
    end

    // Clears the predicted state and loads the reset register values.
    task automatic predictor_reset();
        for (int b = 0; b < NBTN; b++)
        begin
            raw_prev[b] = 1'b0;
            settled[b]  = 1'b0;
            hold_ms[b]  = '0;
        end
        since_tick     = '0;
        page_now       = 0;
        focus_now      = 0;
        partial_run    = '0;
        cur_debounce   = DEBOUNCE_RESET;
        cur_period     = PERIOD_RESET;
        cur_scrub_gap  = FULL_RESET;
    endtask

    // Advances the predictor by one millisecond and queues the redraw it causes, if any.
    task automatic predict_ms(input bnrc_in_t lv);
        logic [NBTN-1:0] levels;
        logic [NBTN-1:0] pressed;
        logic            raw;
        bit              tick;
        bit              page_moved;
        bit              touched;
        bit              toggle;
        bit              full;
        bnrc_out_t       res;

        levels = {lv.confirm_level, lv.down_level, lv.up_level, lv.exit_level, lv.menu_level};

        // Per-button debouncing: a press is reported once per settled change to pressed.
        for (int b = 0; b < NBTN; b++)
        begin
            raw = ~levels[b];
            if (raw != raw_prev[b])
            begin
                raw_prev[b] = raw;
                hold_ms[b]  = '0;
            end
            else if (hold_ms[b] != COUNT_MAX)
            begin
                hold_ms[b]++;
            end
            pressed[b] = 1'b0;
            if (hold_ms[b] >= cur_debounce && raw != settled[b])
            begin
                settled[b] = raw;
                pressed[b] = raw;
            end
        end

        // Periodic data tick.
        tick       = 1'b0;
        page_moved = 1'b0;
        touched    = 1'b0;
        toggle     = 1'b0;
        if (since_tick != TICK_MAX)
            since_tick++;
        if (since_tick >= cur_period)
        begin
            since_tick = '0;
            tick       = 1'b1;
            page_moved = 1'b1;
        end

        // Page stepping: menu goes back first, then exit goes forward.
        if (pressed[BTN_MENU])
        begin
            page_now   = (page_now + N_PAGES - 1) % N_PAGES;
            page_moved = 1'b1;
        end
        if (pressed[BTN_EXIT])
        begin
            page_now   = (page_now + 1) % N_PAGES;
            page_moved = 1'b1;
        end

        // Focus and toggle act only on a settled actuator page.
        if (page_now == int'(ACT_PAGE) && !page_moved)
        begin
            if (pressed[BTN_UP])
            begin
                focus_now = (focus_now + N_ROWS - 1) % N_ROWS;
                touched   = 1'b1;
            end
            if (pressed[BTN_DOWN])
            begin
                focus_now = (focus_now + 1) % N_ROWS;
                touched   = 1'b1;
            end
            if (pressed[BTN_CONF])
            begin
                toggle  = 1'b1;
                touched = 1'b1;
            end
        end

        // Full or partial redraw, with a full scrub after enough partials.
        full = 1'b0;
        if (page_moved)
        begin
            full        = 1'b1;
            partial_run = '0;
        end
        else if (touched)
        begin
            if (partial_run >= cur_scrub_gap)
            begin
                full        = 1'b1;
                partial_run = '0;
            end
            else if (partial_run != PARTIAL_MAX)
            begin
                partial_run++;
            end
        end

        if (page_moved || touched)
        begin
            res.page_shown     = 2'(page_now);
            res.focus_row      = 2'(focus_now);
            res.full_redraw    = full;
            res.data_refresh   = tick;
            res.toggle_request = toggle;
            redraw_q.push_back(res);
        end
    endtask

    // Sends one millisecond request; called and returns at a falling edge.
    task automatic send_ms(input bnrc_in_t lv);
        while (!calm && $urandom_range(99) < 6)
        begin
            in_valid = 1'b0;
            @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = lv;
        do
            @(posedge clk);
        while (in_stall);
        predict_ms(lv);
        ms_sent++;
        @(negedge clk);
    endtask

    // Turns a mask of held buttons into the active-low pin levels.
    function automatic bnrc_in_t levels_for(input logic [NBTN-1:0] held);
        bnrc_in_t lv;
        lv.menu_level    = ~held[BTN_MENU];
        lv.exit_level    = ~held[BTN_EXIT];
        lv.up_level      = ~held[BTN_UP];
        lv.down_level    = ~held[BTN_DOWN];
        lv.confirm_level = ~held[BTN_CONF];
        return lv;
    endfunction

    // Holds the given buttons for a number of milliseconds, then releases them as long.
    task automatic tap(input logic [NBTN-1:0] held, input int span);
        repeat (span) send_ms(levels_for(held));
        repeat (span) send_ms(levels_for(HOLD_NONE));
    endtask

    // Writes one register while the block is idle; returns at a falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        case (idx)
            CFG_DEBOUNCE_MS: cur_debounce   = data[DB_W-1:0];
            CFG_REFRESH_MS:  cur_period     = data[PERIOD_W-1:0];
            CFG_SCRUB_GAP:   cur_scrub_gap  = data[FULL_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // Stops sending and waits until every predicted redraw has been taken.
    task automatic settle_block();
        in_valid = 1'b0;
        while (redraw_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic check_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endtask

    // Compares each accepted redraw request with the oldest prediction.
    always @(posedge clk)
    begin
        bnrc_out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (redraw_q.size() == 0)
            begin
                $error("redraw request with none predicted: %p", out_data);
                mismatches++;
            end
            else
            begin
                want = redraw_q.pop_front();
                check_field("page_shown", int'(want.page_shown), int'(out_data.page_shown));
                check_field("focus_row", int'(want.focus_row), int'(out_data.focus_row));
                check_field("full_redraw", int'(want.full_redraw),
                            int'(out_data.full_redraw));
                check_field("data_refresh", int'(want.data_refresh),
                            int'(out_data.data_refresh));
                check_field("toggle_request", int'(want.toggle_request),
                            int'(out_data.toggle_request));
            end
        end
    end

    // Reset values: one menu press held just long enough for the default debounce.
    task automatic test_defaults();
        tap(HOLD_MENU, int'(DEBOUNCE_RESET) + 1);
    endtask

    // Page wrap in both directions and several button combinations on the actuator page.
    task automatic test_page_wrap();
        settle_block();
        write_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'($urandom() << DB_W));
        write_reg(CFG_REFRESH_MS, TICK_MAX);
        write_reg(CFG_SCRUB_GAP, CFG_DATA_W'(0));
        tap(HOLD_EXIT, 1);
        tap(HOLD_EXIT, 1);
        tap(HOLD_EXIT, 1);
        tap(HOLD_MENU, 1);
        tap(HOLD_MENU | HOLD_EXIT, 1);
        tap(HOLD_MENU, 1);
        tap(HOLD_MENU, 1);
        tap(HOLD_DOWN, 1);
        tap(HOLD_UP, 1);
        tap(HOLD_CONF, 1);
        tap(HOLD_UP | HOLD_DOWN, 1);
        tap('1, 1);
        tap(HOLD_DOWN | HOLD_CONF, 1);
    endtask

    // Partial redraws turning into full scrubs, at a small and at the largest spacing.
    task automatic test_partials();
        settle_block();
        write_reg(CFG_SCRUB_GAP, CFG_DATA_W'(($urandom() << FULL_W) | 3));
        repeat (6) tap(HOLD_DOWN, 1);
        settle_block();
        write_reg(CFG_SCRUB_GAP, CFG_DATA_W'(31));
        repeat (34) tap(HOLD_DOWN, 1);
    endtask

    // Data tick at periods of one and zero, and a short period mixed with presses.
    task automatic test_tick();
        settle_block();
        write_reg(CFG_REFRESH_MS, CFG_DATA_W'(1));
        repeat (4) send_ms(levels_for(HOLD_NONE));
        settle_block();
        write_reg(CFG_REFRESH_MS, CFG_DATA_W'(0));
        repeat (4) send_ms(levels_for(HOLD_NONE));
        settle_block();
        write_reg(CFG_REFRESH_MS, CFG_DATA_W'(5));
        repeat (4) tap(HOLD_CONF, 1);
        tap(HOLD_UP, 2);
    endtask

    // Longest debounce: a hold one millisecond short is ignored, a full one is accepted.
    task automatic test_long_debounce();
        settle_block();
        write_reg(CFG_REFRESH_MS, TICK_MAX);
        write_reg(CFG_DEBOUNCE_MS, '1);
        repeat (int'(COUNT_MAX)) send_ms(levels_for(HOLD_DOWN));
        send_ms(levels_for(HOLD_NONE));
        repeat (int'(COUNT_MAX) + 1) send_ms(levels_for(HOLD_DOWN));
        send_ms(levels_for(HOLD_NONE));
    endtask

    // A write to the unused index must leave every register as it was.
    task automatic test_unused_index();
        settle_block();
        write_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'(1));
        write_reg(CFG_UNUSED_IDX, CFG_DATA_W'(0));
        tap(HOLD_CONF, 2);
        tap(HOLD_UP, 2);
    endtask

    // Random gesture: mostly clean presses with random buttons, some chatter and noise.
    task automatic random_gesture(input int db);
        logic [NBTN-1:0] held;
        bnrc_in_t        noise;
        int              pick;
        if ($urandom_range(99) < 80)
        begin
            pick = int'($urandom_range(99));
            if (pick < 55)
                held = NBTN'(1 << $urandom_range(BTN_CONF, BTN_UP));
            else if (pick < 80)
                held = NBTN'(1 << $urandom_range(BTN_EXIT, BTN_MENU));
            else
                held = NBTN'($urandom_range(31, 1));
            if ($urandom_range(3) == 0)
            begin
                repeat ($urandom_range(3, 1))
                begin
                    noise = NBTN'($urandom_range(31));
                    send_ms(noise);
                end
            end
            tap(held, db + 1 + int'($urandom_range(2)));
        end
        else
        begin
            repeat ($urandom_range(6, 1))
            begin
                noise = NBTN'($urandom_range(31));
                send_ms(noise);
            end
        end
    endtask

    // Random phases, each with fresh registers; the second runs with no idling at all.
    task automatic test_random();
        int target;
        int phase_end;
        int db;
        int phase;
        target = ms_sent + RANDOM_MS;
        phase  = 0;
        while (ms_sent < target)
        begin
            settle_block();
            db = ($urandom_range(9) < 7) ? int'($urandom_range(3)) : int'($urandom_range(12, 4));
            write_reg(CFG_DEBOUNCE_MS, CFG_DATA_W'(db));
            write_reg(CFG_REFRESH_MS, CFG_DATA_W'($urandom_range(400, 15)));
            write_reg(CFG_SCRUB_GAP,
                      CFG_DATA_W'(($urandom_range(3) == 0) ? $urandom_range(31)
                                                           : $urandom_range(4)));
            calm      = (phase == 1);
            phase_end = ms_sent + (calm ? 150 : int'($urandom_range(160, 90)));
            while (ms_sent < phase_end)
                random_gesture(db);
            calm = 1'b0;
            phase++;
        end
    endtask

    // Reset, the directed tests, the random part, then the verdict.
    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '1;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        predictor_reset();
        repeat (5) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_defaults();
        test_page_wrap();
        test_partials();
        test_tick();
        test_long_debounce();
        test_unused_index();
        test_random();

        settle_block();
        if (mismatches == 0)
            $display("button_nav_refresh_controller_unit test passed");
        else
            $display("button_nav_refresh_controller_unit test failed");
        $finish;
    end

    // Guard against a hung handshake.
    initial
    begin
        #2_000_000;
        $display("button_nav_refresh_controller_unit test failed");
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/bnrc_pkg.sv
hw/rtl/bnrc_debounce.sv
hw/rtl/button_nav_refresh_controller_unit.sv
hw/rtl/bnrc_checker.sv
tb/sv/tb_top.sv
